@@ rtl/cctb_pkg.sv @@
`default_nettype none
package cctb_pkg;

  // operation codes
  localparam logic [2:0] OP_ISR_START     = 3'd0;
  localparam logic [2:0] OP_ISR_END       = 3'd1;
  localparam logic [2:0] OP_SAMPLE_TICK   = 3'd2;
  localparam logic [2:0] OP_READ_US       = 3'd3;
  localparam logic [2:0] OP_READ_MS       = 3'd4;
  localparam logic [2:0] OP_READ_ISR_LOAD = 3'd5;
  localparam logic [2:0] OP_RESET_MS      = 3'd6;
  localparam logic [2:0] OP_RESET_US      = 3'd7;

  // configuration register indexes
  localparam logic CFG_CYCLES_PER_US  = 1'b0;
  localparam logic CFG_SAMPLES_PER_MS = 1'b1;

  localparam logic [7:0]  CYCLES_PER_US_RST  = 8'd120;
  localparam logic [15:0] SAMPLES_PER_MS_RST = 16'd5;

  // XOR pattern between the previous and the captured start quadrant that marks a quadrant step
  localparam logic [1:0] QUAD_STEP = 2'b01;

  // divider pass lengths: full 64-bit dividend, or a 32-bit one
  localparam logic [6:0] DIV_STEPS_WIDE   = 7'd64;
  localparam logic [6:0] DIV_STEPS_NARROW = 7'd32;

endpackage
`default_nettype wire

@@ rtl/cycle_counter_timebase_unit.sv @@
// Cycle-counter timebase. Each word on the input channel carries an operation
// and the current value of the free-running 32-bit cycle counter, and causes
// exactly one result word. Interrupt start/end capture, millisecond counting,
// load reads and resets finish in the idle state. read_us runs a 32-step pass of
// the shared bit-serial divider and a sample tick that sees the start cycle
// step between the two upper quadrants runs a 64-step pass (wrap count times
// 2^32 over cycles_per_us), so those words answer only after the pass; the divider
// retires one quotient bit per cycle and the block takes no new word while it
// runs. Configuration writes (index 0 cycles_per_us, index 1 samples_per_ms)
// are always taken and must arrive only while the block is idle. A
// cycles_per_us of zero divides by one. clear_cycle_counter_o is set on the
// reset_us result to ask the environment to zero its cycle counter.
`default_nettype none
module cycle_counter_timebase_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  operation_i,
  input  wire logic [31:0] cycle_count_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      result_value_o,
  output logic [31:0]      max_cycles_out_o,
  output logic             clear_cycle_counter_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [7:0]  cpu_q, cpu_d;
  logic [15:0] spm_q, spm_d;

  logic [31:0] start_q, start_d;
  logic [31:0] min_q, min_d;
  logic [31:0] max_q, max_d;
  logic [31:0] last_q, last_d;
  logic [31:0] ms_q, ms_d;
  logic [15:0] frac_q, frac_d;
  logic [31:0] prev_q, prev_d;
  logic [31:0] wrap_q, wrap_d;
  logic [31:0] adj_hi_q, adj_hi_d;
  logic [31:0] adj_lo_q, adj_lo_d;
  logic [7:0]  rem_hi_q, rem_hi_d;
  logic [7:0]  rem_lo_q, rem_lo_d;

  // divider
  logic [63:0] dvd_q, dvd_d;
  logic [7:0]  rem_q, rem_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        is_us_q, is_us_d;
  logic        hi_sel_q, hi_sel_d;

  logic        ov_q, ov_d;
  logic [31:0] res_q, res_d;
  logic [31:0] mx_q, mx_d;
  logic        clr_q, clr_d;

  logic [7:0]  div_s;
  logic [8:0]  shifted;
  logic        ge;
  logic [7:0]  diff;
  logic        out_free;
  logic        in_acc;
  logic [31:0] dur;
  logic [15:0] frac_dec;
  logic        quad_cross;
  logic [31:0] wrap_inc;
  logic [31:0] us_dvd;
  logic [31:0] quot;

  assign div_s    = (cpu_q == 8'd0) ? 8'd1 : cpu_q;
  assign shifted  = {rem_q, dvd_q[63]};
  assign ge       = shifted >= {1'b0, div_s};
  // the difference is below the divisor whenever it is used
  assign diff     = shifted[7:0] - div_s;
  assign out_free = !ov_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign in_acc   = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign dur      = cycle_count_i - start_q;
  assign frac_dec = frac_q - 16'd1;
  assign quad_cross = ((start_q[31:30] ^ prev_q[31:30]) == cctb_pkg::QUAD_STEP);
  assign wrap_inc = wrap_q + 32'd1;
  assign us_dvd   = cycle_count_i[31] ? (cycle_count_i - {24'd0, rem_hi_q})
                                      : (cycle_count_i + {24'd0, rem_lo_q});
  assign quot     = dvd_q[31:0];

  always_comb begin
    state_d  = state_q;
    cpu_d    = cpu_q;
    spm_d    = spm_q;
    start_d  = start_q;
    min_d    = min_q;
    max_d    = max_q;
    last_d   = last_q;
    ms_d     = ms_q;
    frac_d   = frac_q;
    prev_d   = prev_q;
    wrap_d   = wrap_q;
    adj_hi_d = adj_hi_q;
    adj_lo_d = adj_lo_q;
    rem_hi_d = rem_hi_q;
    rem_lo_d = rem_lo_q;
    dvd_d    = dvd_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    is_us_d  = is_us_q;
    hi_sel_d = hi_sel_q;
    ov_d     = ov_q;
    res_d    = res_q;
    mx_d     = mx_q;
    clr_d    = clr_q;

    if (cfg_valid_i) begin
      if (cfg_index_i == cctb_pkg::CFG_CYCLES_PER_US) begin
        cpu_d = cfg_data_i[7:0];
      end else begin
        spm_d = cfg_data_i;
      end
    end

    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          // most operations finish here; the divider ones load it and leave
          ov_d  = 1'b1;
          res_d = 32'd0;
          mx_d  = 32'd0;
          clr_d = 1'b0;
          case (operation_i)
            cctb_pkg::OP_ISR_START: begin
              start_d = cycle_count_i;
            end
            cctb_pkg::OP_ISR_END: begin
              last_d = dur;
              if (min_q > dur) min_d = dur;
              if (max_q < dur) max_d = dur;
            end
            cctb_pkg::OP_SAMPLE_TICK: begin
              frac_d = frac_dec;
              if (frac_dec == 16'd0) begin
                ms_d   = ms_q + 32'd1;
                frac_d = spm_q;
              end
              prev_d = start_q;
              if (quad_cross && start_q[31]) begin
                wrap_d  = wrap_inc;
                dvd_d   = {wrap_inc, 32'd0};
                rem_d   = 8'd0;
                cnt_d   = cctb_pkg::DIV_STEPS_WIDE;
                is_us_d = 1'b0;
                ov_d    = 1'b0;
                state_d = S_DIV;
              end else if (quad_cross) begin
                adj_hi_d = adj_lo_q + 32'd1;
                rem_hi_d = div_s - rem_lo_q;
              end
            end
            cctb_pkg::OP_READ_US: begin
              // dividend sits in the top half so 32 steps leave the quotient low
              dvd_d    = {us_dvd, 32'd0};
              rem_d    = 8'd0;
              cnt_d    = cctb_pkg::DIV_STEPS_NARROW;
              is_us_d  = 1'b1;
              hi_sel_d = cycle_count_i[31];
              ov_d     = 1'b0;
              state_d  = S_DIV;
            end
            cctb_pkg::OP_READ_MS: begin
              res_d = ms_q;
            end
            cctb_pkg::OP_READ_ISR_LOAD: begin
              res_d = min_q;
              mx_d  = max_q;
              min_d = last_q;
              max_d = last_q;
            end
            cctb_pkg::OP_RESET_MS: begin
              ms_d   = 32'd0;
              frac_d = spm_q;
            end
            default: begin
              wrap_d   = 32'd0;
              adj_hi_d = 32'd0;
              adj_lo_d = 32'd0;
              rem_hi_d = 8'd0;
              rem_lo_d = 8'd0;
              prev_d   = prev_q - cycle_count_i;
              clr_d    = 1'b1;
            end
          endcase
        end
      end
      S_DIV: begin
        // one restoring step: shift in a dividend bit, subtract if it fits
        rem_d = ge ? diff : shifted[7:0];
        dvd_d = {dvd_q[62:0], ge};
        cnt_d = cnt_q - 7'd1;
        if (cnt_q == 7'd1) state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          ov_d    = 1'b1;
          mx_d    = 32'd0;
          clr_d   = 1'b0;
          state_d = S_IDLE;
          if (is_us_q) begin
            res_d = quot + (hi_sel_q ? adj_hi_q : adj_lo_q);
          end else begin
            res_d    = 32'd0;
            adj_lo_d = quot;
            if (quot != 32'd0) begin
              rem_lo_d = rem_q;
            end else begin
              wrap_d   = 32'd0;
              rem_lo_d = 8'd0;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cpu_q    <= cctb_pkg::CYCLES_PER_US_RST;
      spm_q    <= cctb_pkg::SAMPLES_PER_MS_RST;
      start_q  <= 32'd0;
      min_q    <= '1;
      max_q    <= 32'd0;
      last_q   <= 32'd0;
      ms_q     <= 32'd0;
      frac_q   <= cctb_pkg::SAMPLES_PER_MS_RST;
      prev_q   <= 32'd0;
      wrap_q   <= 32'd0;
      adj_hi_q <= 32'd0;
      adj_lo_q <= 32'd0;
      rem_hi_q <= 8'd0;
      rem_lo_q <= 8'd0;
      cnt_q    <= 7'd0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      cpu_q    <= cpu_d;
      spm_q    <= spm_d;
      start_q  <= start_d;
      min_q    <= min_d;
      max_q    <= max_d;
      last_q   <= last_d;
      ms_q     <= ms_d;
      frac_q   <= frac_d;
      prev_q   <= prev_d;
      wrap_q   <= wrap_d;
      adj_hi_q <= adj_hi_d;
      adj_lo_q <= adj_lo_d;
      rem_hi_q <= rem_hi_d;
      rem_lo_q <= rem_lo_d;
      cnt_q    <= cnt_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q    <= dvd_d;
    rem_q    <= rem_d;
    is_us_q  <= is_us_d;
    hi_sel_q <= hi_sel_d;
    res_q    <= res_d;
    mx_q     <= mx_d;
    clr_q    <= clr_d;
  end

  assign out_valid_o           = ov_q;
  assign result_value_o        = res_q;
  assign max_cycles_out_o      = mx_q;
  assign clear_cycle_counter_o = clr_q;

endmodule
`default_nettype wire

@@ rtl/cctb_checker.sv @@
`default_nettype none
module cctb_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [2:0]  operation_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] result_value_o,
  input wire logic [31:0] max_cycles_out_o,
  input wire logic        clear_cycle_counter_o
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  // a pending word holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_value_o))
    else $error("pending result dropped or changed");

  // after a word is taken, either its result shows or the block is busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o || !in_ready_o)
    else $error("accepted word neither answered nor in progress");

  a_reset_us_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && operation_i == cctb_pkg::OP_RESET_US |=> out_valid_o && clear_cycle_counter_o)
    else $error("reset_us result missing clear request");

  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clear_cycle_counter_o |-> result_value_o == 32'd0
                                         && max_cycles_out_o == 32'd0)
    else $error("clear request carries nonzero values");

endmodule

bind cycle_counter_timebase_unit cctb_checker u_cctb_checker (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .in_valid_i            (in_valid_i),
  .in_ready_o            (in_ready_o),
  .operation_i           (operation_i),
  .out_valid_o           (out_valid_o),
  .out_ready_i           (out_ready_i),
  .result_value_o        (result_value_o),
  .max_cycles_out_o      (max_cycles_out_o),
  .clear_cycle_counter_o (clear_cycle_counter_o)
);
`default_nettype wire
